// File: sv/key_matrix_scan_debounce_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the key matrix scanner
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef KEY_MATRIX_SCAN_DEBOUNCE_UNIT_ASSERT_SVH
`define KEY_MATRIX_SCAN_DEBOUNCE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define KMSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("kmsd assertion failed");
// next-cycle implication
`define KMSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("kmsd assertion failed");
`else
`define KMSD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define KMSD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/kmsd_pkg.sv
// ----------------------------------------------------------------------------
// kmsd_pkg
// Shared widths and constants for the key matrix scanner.
// ----------------------------------------------------------------------------
package kmsd_pkg;

	localparam int unsigned KMSD_ROW_COUNT = 6;
	localparam int unsigned KMSD_COL_COUNT = 8;

	localparam int unsigned SAMPLE_W  = 8;
	localparam int unsigned ROW_FLD_W = 3;
	localparam int unsigned CNT_W     = 8;
	localparam int unsigned THRESH_W  = 8;

	typedef logic [CNT_W-1:0] cnt_t;

	localparam cnt_t                CNT_MAX      = 8'hFF;
	localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd6;

endpackage

// File: sv/kmsd_ifs.sv
// ----------------------------------------------------------------------------
// kmsd channel interfaces
// Valid/ready channels for column samples and scan results.
// ----------------------------------------------------------------------------
interface kmsd_sample_if import kmsd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] column_sample;

	modport source (output valid, output column_sample, input ready);
	modport sink (input valid, input column_sample, output ready);
endinterface

interface kmsd_result_if import kmsd_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [ROW_FLD_W-1:0] scanned_row;
	logic [SAMPLE_W-1:0]  row_keys;
	logic [SAMPLE_W-1:0]  flipped_mask;
	logic                 any_change;
	logic [ROW_FLD_W-1:0] drive_row;

	modport source (
		output valid, output scanned_row, output row_keys, output flipped_mask,
		output any_change, output drive_row, input ready
	);
	modport sink (
		input valid, input scanned_row, input row_keys, input flipped_mask,
		input any_change, input drive_row, output ready
	);
endinterface

// File: sv/kmsd_row_update.sv
// ----------------------------------------------------------------------------
// kmsd_row_update
// Per-column counter debounce for one row of the matrix.
// ----------------------------------------------------------------------------
module kmsd_row_update import kmsd_pkg::*; #(
	parameter int unsigned COL_COUNT = KMSD_COL_COUNT
) (
	input  logic [SAMPLE_W-1:0]  sample,
	input  logic [COL_COUNT-1:0] keys,
	input  cnt_t                 counts [COL_COUNT],
	input  logic [THRESH_W-1:0]  threshold,
	output logic [COL_COUNT-1:0] keys_new,
	output cnt_t                 counts_new [COL_COUNT],
	output logic [SAMPLE_W-1:0]  keys_fld,
	output logic [SAMPLE_W-1:0]  flip_fld
);

	logic [COL_COUNT-1:0] bit_in;
	logic [COL_COUNT-1:0] flip;

	for (genvar c = 0; c < COL_COUNT; c++) begin : g_col
		cnt_t inc;
		logic mism;

		// columns past the sample width read as released
		if (c < SAMPLE_W) begin : g_smp
			assign bit_in[c] = sample[c];
		end else begin : g_zero
			assign bit_in[c] = 1'b0;
		end

		assign mism          = bit_in[c] ^ keys[c];
		assign inc           = (counts[c] == CNT_MAX) ? CNT_MAX : counts[c] + cnt_t'(1);
		assign counts_new[c] = mism ? inc : '0;
		assign flip[c]       = mism && (inc > threshold);
		assign keys_new[c]   = keys[c] ^ flip[c];
	end

	for (genvar b = 0; b < SAMPLE_W; b++) begin : g_fld
		if (b < COL_COUNT) begin : g_used
			assign keys_fld[b] = keys_new[b];
			assign flip_fld[b] = flip[b];
		end else begin : g_unused
			assign keys_fld[b] = 1'b0;
			assign flip_fld[b] = 1'b0;
		end
	end

endmodule

// File: sv/key_matrix_scan_debounce_unit.sv
// ----------------------------------------------------------------------------
// key_matrix_scan_debounce_unit: key matrix scanner with counter debounce
// Pipeline: a sample beat passes the input stage, then the result stage, to become a result beat.
// Throughput: one sample beat per cycle unless result.ready stalls; row state updates as the beat leaves stage one.
// Reset: all keys released, all counters zero, row 0 first, threshold 6.
// ----------------------------------------------------------------------------
`include "key_matrix_scan_debounce_unit_assert.svh"

module key_matrix_scan_debounce_unit import kmsd_pkg::*; #(
	parameter int unsigned ROW_COUNT = KMSD_ROW_COUNT,
	parameter int unsigned COL_COUNT = KMSD_COL_COUNT
) (
	input  logic                clk,
	input  logic                arst_n,
	kmsd_sample_if.sink         sample,
	kmsd_result_if.source       result,
	input  logic                threshold_we,
	input  logic [THRESH_W-1:0] threshold_wdata
);

	localparam int unsigned      ROW_W    = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROW_COUNT - 1);

	// Configuration
	logic [THRESH_W-1:0] threshold_q;

	// Matrix state: one debounced word and one counter set per row
	logic [COL_COUNT-1:0] keys_q [ROW_COUNT];
	cnt_t                 cnt_q  [ROW_COUNT][COL_COUNT];
	logic [ROW_W-1:0]     row_q;

	// Stage one: the registered sample beat
	logic                valid_s1;
	logic [SAMPLE_W-1:0] sample_s1;

	// Stage two: the result register
	logic                valid_s2;
	logic [ROW_W-1:0]    row_s2;
	logic [ROW_W-1:0]    drive_s2;
	logic [SAMPLE_W-1:0] keys_s2;
	logic [SAMPLE_W-1:0] flip_s2;

	logic                 adv_s2;
	logic                 adv_s1;
	logic [ROW_W-1:0]     row_eff;
	logic [ROW_W-1:0]     row_next;
	logic [COL_COUNT-1:0] keys_new;
	cnt_t                 counts_new [COL_COUNT];
	logic [SAMPLE_W-1:0]  keys_fld;
	logic [SAMPLE_W-1:0]  flip_fld;

	logic [ROW_W+ROW_FLD_W-1:0] row_ext;
	logic [ROW_W+ROW_FLD_W-1:0] drive_ext;

	// Handshake: the result register takes a new beat when empty or draining,
	// and stage one frees up whenever its beat moves on.
	assign adv_s2       = !valid_s2 || result.ready;
	assign adv_s1       = valid_s1 && adv_s2;
	assign sample.ready = !valid_s1 || adv_s2;

	// A row index past the last row is taken as row 0; wrap after the last row.
	assign row_eff  = (row_q > LAST_ROW) ? '0 : row_q;
	assign row_next = (row_eff == LAST_ROW) ? '0 : row_eff + ROW_W'(1);

	kmsd_row_update #(
		.COL_COUNT (COL_COUNT)
	) u_row_update (
		.sample     (sample_s1),
		.keys       (keys_q[row_eff]),
		.counts     (cnt_q[row_eff]),
		.threshold  (threshold_q),
		.keys_new   (keys_new),
		.counts_new (counts_new),
		.keys_fld   (keys_fld),
		.flip_fld   (flip_fld)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESH_RESET;
		end else if (threshold_we) begin
			threshold_q <= threshold_wdata;
		end
	end

	// Write back the debounced row and its counters as the beat leaves stage one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			for (int r = 0; r < ROW_COUNT; r++) begin
				keys_q[r] <= '0;
				for (int c = 0; c < COL_COUNT; c++) begin
					cnt_q[r][c] <= '0;
				end
			end
		end else if (adv_s1) begin
			row_q           <= row_next;
			keys_q[row_eff] <= keys_new;
			cnt_q[row_eff]  <= counts_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (sample.ready) begin
				valid_s1 <= sample.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Payload registers: hold while stalled
	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			sample_s1 <= sample.column_sample;
		end
		if (adv_s1) begin
			row_s2   <= row_eff;
			drive_s2 <= row_next;
			keys_s2  <= keys_fld;
			flip_s2  <= flip_fld;
		end
	end

	// Row fields carry the low bits of the row index
	assign row_ext   = {{ROW_FLD_W{1'b0}}, row_s2};
	assign drive_ext = {{ROW_FLD_W{1'b0}}, drive_s2};

	assign result.valid        = valid_s2;
	assign result.scanned_row  = row_ext[ROW_FLD_W-1:0];
	assign result.drive_row    = drive_ext[ROW_FLD_W-1:0];
	assign result.row_keys     = keys_s2;
	assign result.flipped_mask = flip_s2;
	assign result.any_change   = |flip_s2;

	// The next row to drive follows the scanned row with wrap
	`KMSD_ASSERT_NOW(a_drive_follows, clk, arst_n, valid_s2,
		drive_s2 == ((row_s2 == LAST_ROW) ? '0 : row_s2 + ROW_W'(1)))
	// A held beat in stage one keeps its sample while the result stalls
	`KMSD_ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !adv_s2,
		valid_s1 && $stable(sample_s1))
	// The row pointer moves exactly when a beat is processed
	`KMSD_ASSERT_NEXT(a_row_advance, clk, arst_n, adv_s1, row_q == $past(row_next))
	// A flipped key must show its new state as the sampled value
	`KMSD_ASSERT_NOW(a_flip_agrees, clk, arst_n, adv_s1,
		((flip_fld & (keys_fld ^ sample_s1)) == '0))

endmodule
